// ----- rtl/alm_pkg.sv -----
// Types, constants and helpers shared by the linked-list node pool blocks.
package alm_pkg;

   localparam int NODES  = 16;
   localparam int IDX_W  = $clog2(NODES);
   localparam int LINK_W = IDX_W + 1;

   localparam logic [LINK_W-1:0] END_MARK = LINK_W'(NODES);
   localparam logic [31:0]       CLEARED  = 32'hFFFF_FFFF;

   typedef enum logic [1:0] {
      ACT_INSERT   = 2'd0,
      ACT_DELETE   = 2'd1,
      ACT_TRAVERSE = 2'd2,
      ACT_NOP      = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      ST_DONE   = 3'd0,
      ST_FULL   = 3'd1,
      ST_EMPTY  = 3'd2,
      ST_ELEM   = 3'd3,
      ST_NOSUCC = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DEC,
      S_R1,
      S_R2,
      S_W1,
      S_W2,
      S_OUT,
      S_TRV
   } state_type;

   typedef struct packed {
      action_type         action;
      logic               after_head;
      logic [3:0]         pred_index;
      logic signed [31:0] student_number;
      logic signed [31:0] student_mark;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic [3:0]         node_index;
      logic signed [31:0] node_number;
      logic signed [31:0] node_mark;
      logic [3:0]         next_index;
      logic               next_is_end;
      logic               last_of_run;
      logic               list_empty;
      logic               pool_full;
   } rsp_type;

   typedef struct packed {
      logic [31:0]       number;
      logic [31:0]       mark;
      logic [LINK_W-1:0] link;
   } node_type;

   typedef struct packed {
      logic              data_en;
      logic              link_en;
      logic [IDX_W-1:0]  addr;
      node_type          node;
   } node_wr_type;

   // Fold any out-of-range link onto the end marker.
   function automatic logic [LINK_W-1:0] link_norm(input logic [LINK_W-1:0] l);
      logic [LINK_W-1:0] r;
      r = (l >= END_MARK) ? END_MARK : l;
      return r;
   endfunction

endpackage

// ----- rtl/array_linked_list_with_free_pool.sv -----
// Top level: request sequencer, list and free-chain heads, and result register.
// Usage:
//   Requests arrive on req_valid/req_stall/req_data; results leave on
//   rsp_valid/rsp_stall/rsp_data. One request is worked at a time; req_stall
//   is high from acceptance until its last result has been loaded.
//   No-op and errors found at decode load from S_DEC; delete after a tail
//   node reads it and loads from S_R1; insert at head reads and writes the
//   free node, delete at head reads and frees the head node, insert or
//   delete after a node reads and writes two nodes, each then loading from
//   S_OUT. Node memory accesses are dependent (one per cycle, read data
//   registered). A new request is taken the cycle after the result loads.
//   Traverse loads one result per cycle while the result side does not
//   stall, each following a link read from the node memory. A held rsp_stall
//   holds the result register and stops the sequencer in a state with a
//   result to load; no work is lost. Reset empties the list and chains
//   every node into the free pool (per-entry valid bits, no clearing pass).
module array_linked_list_with_free_pool (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  alm_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output alm_pkg::rsp_type rsp_data
);

   alm_pkg::state_type          st_ff, st_in;
   alm_pkg::req_type            req_ff, req_in;
   logic [alm_pkg::LINK_W-1:0]  list_head_ff, list_head_in;
   logic [alm_pkg::LINK_W-1:0]  free_head_ff, free_head_in;
   logic [alm_pkg::LINK_W-1:0]  free_next_ff, free_next_in;
   logic [alm_pkg::LINK_W-1:0]  nx_ff, nx_in;
   logic [alm_pkg::IDX_W-1:0]   t_ff, t_in;
   logic [alm_pkg::IDX_W-1:0]   k_ff, k_in;
   logic [31:0]                 num_ff, num_in;
   logic [31:0]                 mark_ff, mark_in;
   alm_pkg::rsp_type            rsp_ff, rsp_in;
   logic                        rsp_valid_ff, rsp_valid_in;

   logic                        rd_en;
   logic [alm_pkg::IDX_W-1:0]   rd_addr;
   alm_pkg::node_type           rd_node;
   alm_pkg::node_wr_type        wr;

   logic                        out_free;
   logic                        out_load;
   alm_pkg::rsp_type            out_val;
   logic [alm_pkg::LINK_W-1:0]  lnk;
   logic [alm_pkg::LINK_W-1:0]  pred_ext;
   logic                        pred_bad;
   logic                        trv_last;

   alm_node_ram u_ram (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_node (rd_node),
      .wr      (wr)
   );

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign lnk      = alm_pkg::link_norm(rd_node.link);
   assign pred_ext = alm_pkg::LINK_W'(req_ff.pred_index);
   assign pred_bad = pred_ext >= alm_pkg::END_MARK;
   assign trv_last = (lnk == alm_pkg::END_MARK) ||
                     (k_ff == alm_pkg::IDX_W'(alm_pkg::NODES - 1));

   always_comb begin
      st_in        = st_ff;
      req_in       = req_ff;
      list_head_in = list_head_ff;
      free_head_in = free_head_ff;
      free_next_in = free_next_ff;
      nx_in        = nx_ff;
      t_in         = t_ff;
      k_in         = k_ff;
      num_in       = num_ff;
      mark_in      = mark_ff;
      rd_en        = 1'b0;
      rd_addr      = '0;
      wr           = '0;
      out_load     = 1'b0;
      out_val      = '0;
      out_val.last_of_run = 1'b1;
      req_stall    = (st_ff != alm_pkg::S_IDLE);

      case (st_ff)
         alm_pkg::S_IDLE: begin
            if (req_valid) begin
               req_in = req_data;
               st_in  = alm_pkg::S_DEC;
            end
         end

         alm_pkg::S_DEC: begin
            case (req_ff.action)
               alm_pkg::ACT_INSERT: begin
                  if (free_head_ff >= alm_pkg::END_MARK) begin
                     out_val.status = alm_pkg::ST_FULL;
                     out_load       = out_free;
                  end else if (!req_ff.after_head && pred_bad) begin
                     out_val.status = alm_pkg::ST_NOSUCC;
                     out_load       = out_free;
                  end else begin
                     rd_en   = 1'b1;
                     rd_addr = free_head_ff[alm_pkg::IDX_W-1:0];
                     t_in    = free_head_ff[alm_pkg::IDX_W-1:0];
                     st_in   = alm_pkg::S_R1;
                  end
               end
               alm_pkg::ACT_DELETE: begin
                  if (list_head_ff >= alm_pkg::END_MARK) begin
                     out_val.status = alm_pkg::ST_EMPTY;
                     out_load       = out_free;
                  end else if (req_ff.after_head) begin
                     rd_en   = 1'b1;
                     rd_addr = list_head_ff[alm_pkg::IDX_W-1:0];
                     t_in    = list_head_ff[alm_pkg::IDX_W-1:0];
                     st_in   = alm_pkg::S_R2;
                  end else if (pred_bad) begin
                     out_val.status = alm_pkg::ST_NOSUCC;
                     out_load       = out_free;
                  end else begin
                     rd_en   = 1'b1;
                     rd_addr = req_ff.pred_index[alm_pkg::IDX_W-1:0];
                     st_in   = alm_pkg::S_R1;
                  end
               end
               alm_pkg::ACT_TRAVERSE: begin
                  if (list_head_ff >= alm_pkg::END_MARK) begin
                     out_val.status = alm_pkg::ST_EMPTY;
                     out_load       = out_free;
                  end else begin
                     rd_en   = 1'b1;
                     rd_addr = list_head_ff[alm_pkg::IDX_W-1:0];
                     t_in    = list_head_ff[alm_pkg::IDX_W-1:0];
                     k_in    = '0;
                     st_in   = alm_pkg::S_TRV;
                  end
               end
               default: begin
                  out_val.status = alm_pkg::ST_DONE;
                  out_load       = out_free;
               end
            endcase
            if (out_load) begin
               st_in = alm_pkg::S_IDLE;
            end
         end

         alm_pkg::S_R1: begin
            if (req_ff.action == alm_pkg::ACT_INSERT) begin
               free_next_in = lnk;
               if (req_ff.after_head) begin
                  st_in = alm_pkg::S_W1;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = req_ff.pred_index[alm_pkg::IDX_W-1:0];
                  st_in   = alm_pkg::S_R2;
               end
            end else if (lnk == alm_pkg::END_MARK) begin
               // Predecessor is the tail: hold until the result slot frees.
               out_val.status = alm_pkg::ST_NOSUCC;
               out_load       = out_free;
               if (out_free) begin
                  st_in = alm_pkg::S_IDLE;
               end
            end else begin
               rd_en   = 1'b1;
               rd_addr = lnk[alm_pkg::IDX_W-1:0];
               t_in    = lnk[alm_pkg::IDX_W-1:0];
               st_in   = alm_pkg::S_R2;
            end
         end

         alm_pkg::S_R2: begin
            nx_in = lnk;
            if (req_ff.action == alm_pkg::ACT_DELETE) begin
               num_in  = rd_node.number;
               mark_in = rd_node.mark;
            end
            st_in = alm_pkg::S_W1;
         end

         alm_pkg::S_W1: begin
            if (req_ff.action == alm_pkg::ACT_INSERT) begin
               wr.data_en     = 1'b1;
               wr.link_en     = 1'b1;
               wr.addr        = t_ff;
               wr.node.number = req_ff.student_number;
               wr.node.mark   = req_ff.student_mark;
               wr.node.link   = req_ff.after_head ? list_head_ff : nx_ff;
               num_in         = req_ff.student_number;
               mark_in        = req_ff.student_mark;
               free_head_in   = free_next_ff;
               if (req_ff.after_head) begin
                  list_head_in = alm_pkg::LINK_W'(t_ff);
                  nx_in        = list_head_ff;
                  st_in        = alm_pkg::S_OUT;
               end else begin
                  st_in = alm_pkg::S_W2;
               end
            end else begin
               if (req_ff.after_head) begin
                  list_head_in = nx_ff;
               end else begin
                  wr.link_en   = 1'b1;
                  wr.addr      = req_ff.pred_index[alm_pkg::IDX_W-1:0];
                  wr.node.link = nx_ff;
               end
               st_in = alm_pkg::S_W2;
            end
         end

         alm_pkg::S_W2: begin
            if (req_ff.action == alm_pkg::ACT_INSERT) begin
               wr.link_en   = 1'b1;
               wr.addr      = req_ff.pred_index[alm_pkg::IDX_W-1:0];
               wr.node.link = alm_pkg::LINK_W'(t_ff);
               // A free node used as its own predecessor ends up self-linked.
               if (req_ff.pred_index[alm_pkg::IDX_W-1:0] == t_ff) begin
                  nx_in = alm_pkg::LINK_W'(t_ff);
               end
            end else begin
               wr.data_en     = 1'b1;
               wr.link_en     = 1'b1;
               wr.addr        = t_ff;
               wr.node.number = alm_pkg::CLEARED;
               wr.node.mark   = alm_pkg::CLEARED;
               wr.node.link   = free_head_ff;
               free_head_in   = alm_pkg::LINK_W'(t_ff);
            end
            st_in = alm_pkg::S_OUT;
         end

         alm_pkg::S_OUT: begin
            out_val.status      = alm_pkg::ST_DONE;
            out_val.node_index  = 4'(t_ff);
            out_val.node_number = num_ff;
            out_val.node_mark   = mark_ff;
            out_val.next_is_end = (nx_ff == alm_pkg::END_MARK);
            out_val.next_index  = out_val.next_is_end ? 4'd0 : 4'(nx_ff);
            out_load            = out_free;
            if (out_free) begin
               st_in = alm_pkg::S_IDLE;
            end
         end

         alm_pkg::S_TRV: begin
            out_val.status      = alm_pkg::ST_ELEM;
            out_val.node_index  = 4'(t_ff);
            out_val.node_number = rd_node.number;
            out_val.node_mark   = rd_node.mark;
            out_val.next_is_end = (lnk == alm_pkg::END_MARK);
            out_val.next_index  = out_val.next_is_end ? 4'd0 : 4'(lnk);
            out_val.last_of_run = trv_last;
            out_load            = out_free;
            if (out_free) begin
               if (trv_last) begin
                  st_in = alm_pkg::S_IDLE;
               end else begin
                  // Advance: fetch the successor while this node goes out.
                  rd_en   = 1'b1;
                  rd_addr = lnk[alm_pkg::IDX_W-1:0];
                  t_in    = lnk[alm_pkg::IDX_W-1:0];
                  k_in    = k_ff + alm_pkg::IDX_W'(1);
               end
            end
         end

         default: begin
            st_in = alm_pkg::S_IDLE;
         end
      endcase

      // Heads only move in the write states, so these are the post-step flags.
      out_val.list_empty = (list_head_ff >= alm_pkg::END_MARK);
      out_val.pool_full  = (free_head_ff >= alm_pkg::END_MARK);

      rsp_in       = out_load ? out_val : rsp_ff;
      rsp_valid_in = out_load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= alm_pkg::S_IDLE;
         list_head_ff <= alm_pkg::END_MARK;
         free_head_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         list_head_ff <= list_head_in;
         free_head_ff <= free_head_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      free_next_ff <= free_next_in;
      nx_ff        <= nx_in;
      t_ff         <= t_in;
      k_ff         <= k_in;
      num_ff       <= num_in;
      mark_ff      <= mark_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // The sequencer never reads and writes the node memory in the same cycle.
   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      !(rd_en && (wr.data_en || wr.link_en)))
      else $error("node memory read and write in the same cycle");

   // A traverse result that is not the last keeps the walk going.
   a_trv_continues: assert property (@(posedge clock) disable iff (reset)
      (out_load && !out_val.last_of_run) |=> (st_ff == alm_pkg::S_TRV))
      else $error("traverse ended before its last result");

   // A list element is never reported from an empty list.
   a_elem_nonempty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.status == alm_pkg::ST_ELEM) |-> !rsp_ff.list_empty)
      else $error("list element reported with the list empty");

   // Heads change only in the write states.
   a_heads_stable: assert property (@(posedge clock) disable iff (reset)
      !(st_ff == alm_pkg::S_W1 || st_ff == alm_pkg::S_W2)
      |=> ($stable(list_head_ff) && $stable(free_head_ff)))
      else $error("list or free head moved outside a write state");

endmodule

// ----- rtl/alm_node_ram.sv -----
// Node store: number, mark and link memories with per-entry reset-value tracking.
module alm_node_ram (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              rd_en,
   input  logic [alm_pkg::IDX_W-1:0]         rd_addr,
   output alm_pkg::node_type                 rd_node,
   input  alm_pkg::node_wr_type              wr
);

   logic [31:0]                 number_mem [alm_pkg::NODES];
   logic [31:0]                 mark_mem   [alm_pkg::NODES];
   logic [alm_pkg::LINK_W-1:0]  link_mem   [alm_pkg::NODES];

   logic [alm_pkg::NODES-1:0]   data_vld_ff, data_vld_in;
   logic [alm_pkg::NODES-1:0]   link_vld_ff, link_vld_in;

   logic [31:0]                 rd_number_ff;
   logic [31:0]                 rd_mark_ff;
   logic [alm_pkg::LINK_W-1:0]  rd_link_ff;
   logic                        rd_dv_ff;
   logic                        rd_lv_ff;
   logic [alm_pkg::IDX_W-1:0]   rd_addr_ff;

   always_ff @(posedge clock) begin
      if (wr.data_en) begin
         number_mem[wr.addr] <= wr.node.number;
         mark_mem[wr.addr]   <= wr.node.mark;
      end
      if (wr.link_en) begin
         link_mem[wr.addr] <= wr.node.link;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_number_ff <= number_mem[rd_addr];
         rd_mark_ff   <= mark_mem[rd_addr];
         rd_link_ff   <= link_mem[rd_addr];
         rd_dv_ff     <= data_vld_ff[rd_addr];
         rd_lv_ff     <= link_vld_ff[rd_addr];
         rd_addr_ff   <= rd_addr;
      end
   end

   always_comb begin
      data_vld_in = data_vld_ff;
      link_vld_in = link_vld_ff;
      if (wr.data_en) begin
         data_vld_in[wr.addr] = 1'b1;
      end
      if (wr.link_en) begin
         link_vld_in[wr.addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         data_vld_ff <= '0;
         link_vld_ff <= '0;
      end else begin
         data_vld_ff <= data_vld_in;
         link_vld_ff <= link_vld_in;
      end
   end

   // Unwritten entries read as their reset value: -1 data, link to the next node.
   always_comb begin
      rd_node.number = rd_dv_ff ? rd_number_ff : alm_pkg::CLEARED;
      rd_node.mark   = rd_dv_ff ? rd_mark_ff   : alm_pkg::CLEARED;
      rd_node.link   = rd_lv_ff ? rd_link_ff
                                : ({1'b0, rd_addr_ff} + alm_pkg::LINK_W'(1));
   end

endmodule

// ----- bench/tb_array_linked_list_with_free_pool.sv -----
// Self-checking bench for the linked-list node pool: list ops, flags and error codes.
module tb_array_linked_list_with_free_pool;
   import alm_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int QUIET_LIMIT = 300;
   localparam int TAIL_CYCLES = 20;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   // mirror of the node pool
   logic [31:0]       stu_num   [NODES];
   logic [31:0]       stu_mark  [NODES];
   logic [LINK_W-1:0] next_link [NODES];
   logic [LINK_W-1:0] head_node;
   logic [LINK_W-1:0] spare_head;

   rsp_type list_rsp_q [$];
   int      walk_q [$];
   int      error_count = 0;
   int      quiet_cycles = 0;
   bit      idle_on = 1'b1;

   array_linked_list_with_free_pool u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [LINK_W-1:0] succ_of(input logic [LINK_W-1:0] n);
      if (n >= END_MARK) return END_MARK;
      if (next_link[n[IDX_W-1:0]] >= END_MARK) return END_MARK;
      return next_link[n[IDX_W-1:0]];
   endfunction

   function automatic void clear_pool();
      for (int i = 0; i < NODES; i++) begin
         stu_num[i]   = CLEARED;
         stu_mark[i]  = CLEARED;
         next_link[i] = LINK_W'(i + 1);
      end
      head_node  = END_MARK;
      spare_head = '0;
   endfunction

   // Node fields are zero when no node is reported.
   function automatic rsp_type node_report(input status_type st,
                                           input logic [LINK_W-1:0] n,
                                           input bit last);
      rsp_type          r;
      logic [LINK_W-1:0] nx;
      r = '0;
      r.status = st;
      if (n < END_MARK) begin
         nx            = succ_of(n);
         r.node_index  = n[IDX_W-1:0];
         r.node_number = stu_num[n[IDX_W-1:0]];
         r.node_mark   = stu_mark[n[IDX_W-1:0]];
         r.next_is_end = (nx >= END_MARK);
         r.next_index  = (nx >= END_MARK) ? 4'd0 : nx[IDX_W-1:0];
      end
      r.last_of_run = last;
      r.list_empty  = (head_node >= END_MARK);
      r.pool_full   = (spare_head >= END_MARK);
      return r;
   endfunction

   function automatic void predict_list_op(input req_type item);
      logic [LINK_W-1:0] t;
      logic [LINK_W-1:0] cur;
      logic [LINK_W-1:0] nx;
      logic [LINK_W-1:0] pred;
      rsp_type           res;
      int                k;
      pred = {1'b0, item.pred_index};
      case (item.action)
         ACT_INSERT: begin
            if (spare_head >= END_MARK) begin
               list_rsp_q.push_back(node_report(ST_FULL, END_MARK, 1'b1));
            end else begin
               t          = spare_head;
               spare_head = succ_of(t);
               stu_num[t[IDX_W-1:0]]  = item.student_number;
               stu_mark[t[IDX_W-1:0]] = item.student_mark;
               if (item.after_head) begin
                  next_link[t[IDX_W-1:0]] = head_node;
                  head_node = t;
               end else begin
                  next_link[t[IDX_W-1:0]]    = succ_of(pred);
                  next_link[pred[IDX_W-1:0]] = t;
               end
               list_rsp_q.push_back(node_report(ST_DONE, t, 1'b1));
            end
         end
         ACT_DELETE: begin
            if (head_node >= END_MARK) begin
               list_rsp_q.push_back(node_report(ST_EMPTY, END_MARK, 1'b1));
            end else if (!item.after_head && succ_of(pred) >= END_MARK) begin
               list_rsp_q.push_back(node_report(ST_NOSUCC, END_MARK, 1'b1));
            end else begin
               t   = item.after_head ? head_node : succ_of(pred);
               // report the node as it was, flags as they are after release
               res = node_report(ST_DONE, t, 1'b1);
               if (item.after_head) head_node = succ_of(t);
               else next_link[pred[IDX_W-1:0]] = succ_of(t);
               next_link[t[IDX_W-1:0]] = spare_head;
               stu_num[t[IDX_W-1:0]]   = CLEARED;
               stu_mark[t[IDX_W-1:0]]  = CLEARED;
               spare_head    = t;
               res.list_empty = (head_node >= END_MARK);
               res.pool_full  = 1'b0;
               list_rsp_q.push_back(res);
            end
         end
         ACT_TRAVERSE: begin
            if (head_node >= END_MARK) begin
               list_rsp_q.push_back(node_report(ST_EMPTY, END_MARK, 1'b1));
            end else begin
               cur = head_node;
               k   = 0;
               // cap the walk in case links were bent into a loop
               while (cur < END_MARK && k < NODES) begin
                  nx = succ_of(cur);
                  list_rsp_q.push_back(node_report(ST_ELEM, cur,
                                                   (nx >= END_MARK) || (k + 1 >= NODES)));
                  k++;
                  cur = nx;
               end
            end
         end
         default: list_rsp_q.push_back(node_report(ST_DONE, END_MARK, 1'b1));
      endcase
   endfunction

   function automatic void walk_list();
      logic [LINK_W-1:0] cur;
      walk_q.delete();
      cur = head_node;
      while (cur < END_MARK && walk_q.size() < NODES) begin
         walk_q.push_back(int'(cur));
         cur = succ_of(cur);
      end
   endfunction

   function automatic logic [31:0] rand_word();
      case ($urandom_range(0, 11))
         0:       return 32'h8000_0000;
         1:       return 32'h7FFF_FFFF;
         2:       return 32'h0000_0000;
         3:       return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   function automatic req_type mk_req(input action_type act, input bit at_head,
                                      input int pred, input logic [31:0] num,
                                      input logic [31:0] mark);
      req_type r;
      r.action         = act;
      r.after_head     = at_head;
      r.pred_index     = pred[IDX_W-1:0];
      r.student_number = num;
      r.student_mark   = mark;
      return r;
   endfunction

   // Mostly well-formed ops on the current list, some raw noise.
   function automatic req_type make_request(input int ins_pct, input int del_pct);
      req_type r;
      int      roll;
      int      n;
      r = mk_req(ACT_NOP, 1'($urandom_range(0, 1)), $urandom_range(0, NODES - 1),
                 rand_word(), rand_word());
      if ($urandom_range(0, 99) < 8) begin
         r.action = action_type'($urandom_range(0, 3));
         return r;
      end
      walk_list();
      n    = walk_q.size();
      roll = $urandom_range(0, 99);
      if (roll < ins_pct) begin
         r.action = ACT_INSERT;
         if (!r.after_head) begin
            if (n == 0) r.after_head = 1'b1;
            else r.pred_index = IDX_W'(walk_q[$urandom_range(0, n - 1)]);
         end
      end else if (roll < ins_pct + del_pct) begin
         r.action = ACT_DELETE;
         if (!r.after_head) begin
            if (n < 2) r.after_head = 1'b1;
            else r.pred_index = IDX_W'(walk_q[$urandom_range(0, n - 2)]);
         end
      end else begin
         r.action = (roll % 3 == 0) ? ACT_NOP : ACT_TRAVERSE;
      end
      return r;
   endfunction

   task automatic send_request(input req_type item);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      predict_list_op(item);
   endtask

   task automatic wait_results_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (list_rsp_q.size() != 0) @(posedge clock);
   endtask

   // result side stalls in short bursts
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (idle_on && $urandom_range(0, 4) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 4)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   function automatic bit field_differs(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
      if (want === got) return 1'b0;
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      return 1'b1;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      bit      bad;
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
         if (rsp_valid && !rsp_stall) begin
            if (list_rsp_q.size() == 0) begin
               $display("%0t: unexpected result: expected none, actual %h",
                        $time, rsp_data);
               error_count++;
            end else begin
               want = list_rsp_q.pop_front();
               bad  = 1'b0;
               bad |= field_differs("status", 32'(want.status), 32'(rsp_data.status));
               bad |= field_differs("node_index", 32'(want.node_index),
                                    32'(rsp_data.node_index));
               bad |= field_differs("node_number", want.node_number, rsp_data.node_number);
               bad |= field_differs("node_mark", want.node_mark, rsp_data.node_mark);
               bad |= field_differs("next_index", 32'(want.next_index),
                                    32'(rsp_data.next_index));
               bad |= field_differs("next_is_end", 32'(want.next_is_end),
                                    32'(rsp_data.next_is_end));
               bad |= field_differs("last_of_run", 32'(want.last_of_run),
                                    32'(rsp_data.last_of_run));
               bad |= field_differs("list_empty", 32'(want.list_empty),
                                    32'(rsp_data.list_empty));
               bad |= field_differs("pool_full", 32'(want.pool_full),
                                    32'(rsp_data.pool_full));
               if (bad) error_count++;
            end
         end
      end
   end

   initial begin
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("Test completed with failures");
      $finish;
   end

   task automatic test_empty_list();
      send_request(mk_req(ACT_NOP, 1'b0, 0, 32'h0, 32'h0));
      send_request(mk_req(ACT_TRAVERSE, 1'b1, 0, 32'h0, 32'h0));
      send_request(mk_req(ACT_DELETE, 1'b1, 0, 32'h0, 32'h0));
      // empty wins over a bad predecessor
      send_request(mk_req(ACT_DELETE, 1'b0, 5, 32'h0, 32'h0));
   endtask

   task automatic test_link_edits();
      send_request(mk_req(ACT_INSERT, 1'b1, 0, 32'h8000_0000, 32'h7FFF_FFFF));
      send_request(mk_req(ACT_INSERT, 1'b0, 0, 32'h7FFF_FFFF, 32'h8000_0000));
      send_request(mk_req(ACT_INSERT, 1'b0, 0, 32'h0000_0000, 32'hFFFF_FFFF));
      send_request(mk_req(ACT_INSERT, 1'b1, 15, 32'hFFFF_FFFF, 32'h0000_0000));
      send_request(mk_req(ACT_TRAVERSE, 1'b0, 0, 32'h0, 32'h0));
      send_request(mk_req(ACT_DELETE, 1'b0, 0, 32'h0, 32'h0));
      // tail and a free node at the end of the chain have no successor
      send_request(mk_req(ACT_DELETE, 1'b0, 1, 32'h0, 32'h0));
      send_request(mk_req(ACT_DELETE, 1'b0, 15, 32'h0, 32'h0));
      send_request(mk_req(ACT_DELETE, 1'b1, 0, 32'h0, 32'h0));
      send_request(mk_req(ACT_NOP, 1'b1, 15, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
      send_request(mk_req(ACT_INSERT, 1'b0, 1, $urandom, $urandom));
      send_request(mk_req(ACT_TRAVERSE, 1'b0, 0, 32'h0, 32'h0));
      send_request(mk_req(ACT_DELETE, 1'b0, 1, 32'h0, 32'h0));
      send_request(mk_req(ACT_DELETE, 1'b1, 0, 32'h0, 32'h0));
      send_request(mk_req(ACT_DELETE, 1'b1, 0, 32'h0, 32'h0));
      send_request(mk_req(ACT_TRAVERSE, 1'b0, 0, 32'h0, 32'h0));
   endtask

   task automatic test_fill_and_drain();
      int extra;
      for (int round = 0; round < 2; round++) begin
         extra = 0;
         for (int i = 0; i < 100 && extra < 3; i++) begin
            send_request(make_request(90, 5));
            if (spare_head >= END_MARK) extra++;
         end
         send_request(mk_req(ACT_TRAVERSE, 1'b0, 0, 32'h0, 32'h0));
         extra = 0;
         for (int i = 0; i < 100 && extra < 2; i++) begin
            send_request(make_request(5, 90));
            if (head_node >= END_MARK) extra++;
         end
      end
   endtask

   task automatic test_results_drained();
      for (int i = 0; i < 20; i++) send_request(make_request(40, 20));
      // hold off until every result is back
      wait_results_drained();
      for (int i = 0; i < 20; i++) send_request(make_request(30, 30));
   endtask

   task automatic test_random_traffic();
      int ins_pct;
      int del_pct;
      for (int chunk = 0; chunk < 8; chunk++) begin
         idle_on = ($urandom_range(0, 2) != 0);
         case (chunk % 3)
            0:       begin ins_pct = 55; del_pct = 20; end
            1:       begin ins_pct = 20; del_pct = 55; end
            default: begin ins_pct = 35; del_pct = 35; end
         endcase
         for (int i = 0; i < 45; i++) send_request(make_request(ins_pct, del_pct));
      end
   endtask

   // Predecessors off the list: links are edited without any check.
   task automatic test_stray_links();
      int stray;
      bit listed [NODES];
      idle_on = 1'b0;
      for (int i = 0; i < 6; i++) begin
         walk_list();
         foreach (listed[n]) listed[n] = 1'b0;
         foreach (walk_q[j]) listed[walk_q[j]] = 1'b1;
         stray = NODES - 1;
         for (int n = NODES - 1; n >= 0; n--) if (!listed[n]) stray = n;
         send_request(mk_req((i % 2) ? ACT_DELETE : ACT_INSERT, 1'b0, stray,
                             rand_word(), rand_word()));
      end
      send_request(mk_req(ACT_TRAVERSE, 1'b0, 0, 32'h0, 32'h0));
      send_request(mk_req(ACT_NOP, 1'b0, 0, 32'h0, 32'h0));
   endtask

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      clear_pool();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_empty_list();
      test_link_edits();
      test_fill_and_drain();
      test_results_drained();
      test_random_traffic();
      test_stray_links();
      wait_results_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0 && list_rsp_q.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// ----- files.f -----
rtl/alm_pkg.sv
rtl/alm_node_ram.sv
rtl/array_linked_list_with_free_pool.sv
bench/tb_array_linked_list_with_free_pool.sv
